[sv/sspu_pkg.sv]
// Shared types and constants for the shard scaling hysteresis policy unit.
// Holds the item, result, counter and configuration structs and the code enums.
// No dependencies.
`timescale 1ns / 1ps

package sspu_pkg;

  // default sizing, overridable on the top level
  localparam int MaxWorkersDef = 16;
  localparam int CountBitsDef  = 16;

  // fixed field widths
  localparam int CountW  = 16;
  localparam int FloorW  = 5;
  localparam int MaskW   = 16;
  localparam int WorkerW = 4;
  localparam int StreakW = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 8;

  // policy constants
  localparam logic [FloorW-1:0]  FloorWcMin   = 5'd8;   // io floor only above this many workers
  localparam int                 FloorShift   = 2;      // floor keeps all but a quarter
  localparam int                 LoadShift    = 1;      // two tasks per online worker
  localparam logic [FloorW-1:0]  ScaleWcMin   = 5'd2;   // fewer workers disables scaling
  localparam logic [StreakW-1:0] StreakSat    = 8'd255;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCALING_ENABLE   = 3'd0,
    CFG_WORKER_COUNT     = 3'd1,
    CFG_UP_RUN_NEEDED    = 3'd2,
    CFG_DOWN_RUN_NEEDED  = 3'd3,
    CFG_COOLDOWN_TICKS   = 3'd4
  } cfg_idx_e;

  // result action codes
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_RESTORE = 3'd1,
    ACT_UP      = 3'd2,
    ACT_DOWN    = 3'd3,
    ACT_FAIL    = 3'd4
  } action_e;

  typedef struct packed {
    logic               scaling_enable;
    logic [FloorW-1:0]  worker_count;
    logic [StreakW-1:0] up_run_needed;
    logic [StreakW-1:0] down_run_needed;
    logic [StreakW-1:0] cooldown_ticks;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0] live_tasks;
    logic [CountW-1:0] io_waiters;
    logic              timer_armed;
    logic [FloorW-1:0] floor_count;
    logic              pressure;
    logic              work_backlog;
    logic              blocking_pending;
    logic              opaque_blocking;
    logic [MaskW-1:0]  drain_ok_mask;
  } item_t;

  typedef struct packed {
    logic [StreakW-1:0] up_run;
    logic [StreakW-1:0] down_run;
    logic [StreakW-1:0] cooldown_left;
  } ctr_t;

  typedef struct packed {
    logic [MaskW-1:0]   online_mask_out;
    logic [FloorW-1:0]  online_count;
    action_e            action;
    logic [WorkerW-1:0] changed_worker;
  } res_t;

endpackage

[sv/sspu_decide.sv]
// Per-tick scaling decision: load estimate, floor, hysteresis, cooldown and
// worker selection by priority encoders. Purely combinational.
// Depends on sspu_pkg.
`timescale 1ns / 1ps

module sspu_decide import sspu_pkg::*; #(
  parameter int MAX_WORKERS = MaxWorkersDef,
  parameter int COUNT_BITS  = CountBitsDef
) (
  input  logic [MAX_WORKERS-1:0] mask_i,
  input  ctr_t                   ctr_i,
  input  cfg_t                   cfg_i,
  input  item_t                  item_i,
  output logic [MAX_WORKERS-1:0] mask_o,
  output ctr_t                   ctr_o,
  output res_t                   res_o
);

  localparam int CW = $clog2(MAX_WORKERS + 1);
  localparam int IW = $clog2(MAX_WORKERS);
  localparam int EW = COUNT_BITS + 1;

  logic [CW-1:0]          online;
  logic [CW-1:0]          new_count;
  logic [StreakW-1:0]     online8;
  logic [StreakW-1:0]     wc8;
  logic [StreakW-1:0]     floor8;
  logic [FloorW-1:0]      wc;
  logic [FloorW-1:0]      floor_raise;
  logic [FloorW-1:0]      floor_n;
  logic [COUNT_BITS-1:0]  live_c;
  logic [COUNT_BITS-1:0]  io_c;
  logic [COUNT_BITS-1:0]  eff;
  logic                   io_nz;
  logic                   want_up;
  logic                   want_shrink;
  logic                   scale_off;
  logic                   fire_up;
  logic                   fire_dn;
  logic [StreakW-1:0]     cd_dec;
  logic [StreakW-1:0]     up_n;
  logic [StreakW-1:0]     dn_n;
  logic [MAX_WORKERS-1:0] drain_c;
  logic [MAX_WORKERS-1:0] cand_up;
  logic [MAX_WORKERS-1:0] cand_dn;
  logic [IW-1:0]          up_idx;
  logic [IW-1:0]          dn_idx;
  action_e                act;
  logic [IW-1:0]          chg;

  // online population count
  always_comb begin
    online = '0;
    for (int i = 0; i < MAX_WORKERS; i++) begin
      online = online + CW'(mask_i[i]);
    end
  end

  // effective worker count, clipped to the built size
  assign wc = (int'(cfg_i.worker_count) > MAX_WORKERS) ? FloorW'(MAX_WORKERS)
                                                        : cfg_i.worker_count;
  assign scale_off = !cfg_i.scaling_enable || (wc < ScaleWcMin);

  // load estimate
  assign live_c = COUNT_BITS'(item_i.live_tasks);
  assign io_c   = COUNT_BITS'(item_i.io_waiters);
  assign io_nz  = |io_c;
  assign eff    = (live_c > io_c) ? (live_c - io_c) : '0;

  // floor, raised while tasks wait on io in a large pool
  assign floor_raise = wc - (wc >> FloorShift);
  assign floor_n = (io_nz && (wc > FloorWcMin) && (floor_raise > item_i.floor_count))
                   ? floor_raise : item_i.floor_count;

  assign online8 = StreakW'(online);
  assign wc8     = StreakW'(wc);
  assign floor8  = StreakW'(floor_n);

  // scaling wishes
  assign want_up = (item_i.pressure
                    || (eff > COUNT_BITS'(online8 << LoadShift))
                    || (io_nz && item_i.work_backlog)
                    || (online8 < floor8))
                   && (online8 < wc8);
  assign want_shrink = !item_i.pressure && (online8 > floor8)
                       && ((EW'(eff) + EW'(1) < EW'(online8)) || item_i.timer_armed)
                       && !item_i.blocking_pending && !item_i.work_backlog
                       && !item_i.opaque_blocking;

  // cooldown and streaks
  assign cd_dec = (ctr_i.cooldown_left != '0) ? ctr_i.cooldown_left - 8'd1 : '0;
  assign up_n = !want_up ? '0
              : (ctr_i.up_run == StreakSat) ? StreakSat : ctr_i.up_run + 8'd1;
  assign dn_n = (want_up || !want_shrink) ? '0
              : (ctr_i.down_run == StreakSat) ? StreakSat : ctr_i.down_run + 8'd1;

  assign fire_up = want_up && (cd_dec == '0) && (up_n >= cfg_i.up_run_needed);
  assign fire_dn = want_shrink && (cd_dec == '0) && (dn_n >= cfg_i.down_run_needed);

  // eligible workers, worker 0 never
  assign drain_c = MAX_WORKERS'(item_i.drain_ok_mask);
  always_comb begin
    cand_up = '0;
    cand_dn = '0;
    for (int i = 1; i < MAX_WORKERS; i++) begin
      cand_up[i] = (i < int'(wc)) && !mask_i[i];
      cand_dn[i] = (i < int'(wc)) && mask_i[i] && drain_c[i];
    end
  end

  // lowest offline and highest drainable online worker
  always_comb begin
    up_idx = '0;
    dn_idx = '0;
    for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
      if (cand_up[i]) begin
        up_idx = IW'(i);
      end
    end
    for (int i = 0; i < MAX_WORKERS; i++) begin
      if (cand_dn[i]) begin
        dn_idx = IW'(i);
      end
    end
  end

  // next state and result
  always_comb begin
    mask_o    = mask_i;
    ctr_o     = ctr_i;
    act       = ACT_NONE;
    chg       = '0;
    new_count = online;
    if (scale_off) begin
      act = ACT_NONE;
    end else if (online == '0) begin
      mask_o    = MAX_WORKERS'(1);
      act       = ACT_RESTORE;
      new_count = CW'(1);
    end else begin
      ctr_o.cooldown_left = cd_dec;
      ctr_o.up_run        = up_n;
      ctr_o.down_run      = dn_n;
      if (fire_up) begin
        ctr_o.up_run = '0;
        if (|cand_up) begin
          mask_o[up_idx]      = 1'b1;
          ctr_o.cooldown_left = cfg_i.cooldown_ticks;
          act                 = ACT_UP;
          chg                 = up_idx;
          new_count           = online + CW'(1);
        end else begin
          act = ACT_FAIL;
        end
      end else if (fire_dn) begin
        ctr_o.down_run = '0;
        if (|cand_dn) begin
          mask_o[dn_idx]      = 1'b0;
          ctr_o.cooldown_left = cfg_i.cooldown_ticks;
          act                 = ACT_DOWN;
          chg                 = dn_idx;
          new_count           = online - CW'(1);
        end else begin
          act = ACT_FAIL;
        end
      end
    end
  end

  assign res_o.online_mask_out = MaskW'(mask_o);
  assign res_o.online_count    = FloorW'(new_count);
  assign res_o.action          = act;
  assign res_o.changed_worker  = WorkerW'(chg);

endmodule

[sv/shard_scaling_hysteresis_policy_unit.sv]
// Top level of the shard scaling hysteresis policy unit: channels, input and
// result registers, policy state and configuration registers.
// Depends on sspu_pkg and sspu_decide.
`timescale 1ns / 1ps

// Usage
//   Each input item is one watchdog tick (task counts, floor, flags and the
//   drain mask). For each tick one result item comes back: the online mask
//   after the tick, the online count, the action taken and the worker changed.
//   Channels: in_* and out_* are valid/ready; cfg_* is a write channel that is
//   always ready, index selects the register, unknown indexes are dropped.
//   Configuration should only be written while no tick is in flight.
//   A tick accepted is held in the input register, decided against the policy
//   state as it leaves, and shown on out_* from the result register.
//   Throughput: one tick per cycle; the decision is a single pass of popcount,
//   compares and two priority encoders between the input and result registers.
//   When the receiver stalls, the result register holds and the input register
//   still takes one more tick; in_ready_o drops only when both are full.
//   Reset: worker 0 online only, streaks and cooldown cleared, both stages
//   empty, configuration at its defaults (scaling off, 16 workers, up streak
//   2, down streak 8, cooldown 4).

module shard_scaling_hysteresis_policy_unit import sspu_pkg::*; #(
  parameter int MAX_WORKERS = MaxWorkersDef,
  parameter int COUNT_BITS  = CountBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  // tick items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CountW-1:0]  live_tasks_i,
  input  logic [CountW-1:0]  io_waiters_i,
  input  logic               timer_armed_i,
  input  logic [FloorW-1:0]  floor_count_i,
  input  logic               pressure_i,
  input  logic               work_backlog_i,
  input  logic               blocking_pending_i,
  input  logic               opaque_blocking_i,
  input  logic [MaskW-1:0]   drain_ok_mask_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [MaskW-1:0]   online_mask_out_o,
  output logic [FloorW-1:0]  online_count_o,
  output logic [2:0]         action_o,
  output logic [WorkerW-1:0] changed_worker_o
);

  cfg_t                   cfg_q;
  item_t                  item_q;
  item_t                  item_d;
  logic                   s1_valid_q;
  logic                   out_valid_q;
  res_t                   res_q;
  res_t                   res_d;
  logic [MAX_WORKERS-1:0] mask_q;
  logic [MAX_WORKERS-1:0] mask_d;
  ctr_t                   ctr_q;
  ctr_t                   ctr_d;
  logic                   s1_adv;
  logic                   s1_fire;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scaling_enable  <= 1'b0;
      cfg_q.worker_count    <= 5'd16;
      cfg_q.up_run_needed   <= 8'd2;
      cfg_q.down_run_needed <= 8'd8;
      cfg_q.cooldown_ticks  <= 8'd4;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SCALING_ENABLE:  cfg_q.scaling_enable  <= cfg_data_i[0];
        CFG_WORKER_COUNT:    cfg_q.worker_count    <= cfg_data_i[FloorW-1:0];
        CFG_UP_RUN_NEEDED:   cfg_q.up_run_needed   <= cfg_data_i;
        CFG_DOWN_RUN_NEEDED: cfg_q.down_run_needed <= cfg_data_i;
        CFG_COOLDOWN_TICKS:  cfg_q.cooldown_ticks  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // pipeline handshake
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_ready_o = !s1_valid_q || s1_adv;

  // input register
  always_comb begin
    item_d.live_tasks       = live_tasks_i;
    item_d.io_waiters       = io_waiters_i;
    item_d.timer_armed      = timer_armed_i;
    item_d.floor_count      = floor_count_i;
    item_d.pressure         = pressure_i;
    item_d.work_backlog     = work_backlog_i;
    item_d.blocking_pending = blocking_pending_i;
    item_d.opaque_blocking  = opaque_blocking_i;
    item_d.drain_ok_mask    = drain_ok_mask_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

  // decision logic
  sspu_decide #(
    .MAX_WORKERS (MAX_WORKERS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_decide (
    .mask_i (mask_q),
    .ctr_i  (ctr_q),
    .cfg_i  (cfg_q),
    .item_i (item_q),
    .mask_o (mask_d),
    .ctr_o  (ctr_d),
    .res_o  (res_d)
  );

  // policy state, updated as each item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= MAX_WORKERS'(1);
      ctr_q  <= '0;
    end else if (s1_fire) begin
      mask_q <= mask_d;
      ctr_q  <= ctr_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign online_mask_out_o = res_q.online_mask_out;
  assign online_count_o    = res_q.online_count;
  assign action_o          = res_q.action;
  assign changed_worker_o  = res_q.changed_worker;

  // worker 0 is never taken offline
  a_worker0_online: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_q[0])
    else $error("worker 0 went offline");

  // back-pressure only when both stages hold an item
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  // a successful change loads the cooldown
  a_cooldown_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (res_d.action == ACT_UP || res_d.action == ACT_DOWN))
    |=> (ctr_q.cooldown_left == $past(cfg_q.cooldown_ticks)))
    else $error("cooldown not loaded after a scaling change");

endmodule

[verif/tb_shard_scaling_hysteresis_policy_unit.sv]
// Self-checking testbench for the shard scaling hysteresis policy unit.
// Ticks go in, each result is checked against an in-bench policy predictor.
// Depends on sspu_pkg and shard_scaling_hysteresis_policy_unit.
`timescale 1ns / 1ps

module tb_shard_scaling_hysteresis_policy_unit;
  import sspu_pkg::*;

  localparam int QuietLimit = 1000;

  // tick kinds used by the random stimulus
  localparam int KindLoad  = 0;
  localparam int KindQuiet = 1;
  localparam int KindNoise = 2;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDatW-1:0] cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [CountW-1:0]  live_tasks_i = '0;
  logic [CountW-1:0]  io_waiters_i = '0;
  logic               timer_armed_i = 1'b0;
  logic [FloorW-1:0]  floor_count_i = '0;
  logic               pressure_i = 1'b0;
  logic               work_backlog_i = 1'b0;
  logic               blocking_pending_i = 1'b0;
  logic               opaque_blocking_i = 1'b0;
  logic [MaskW-1:0]   drain_ok_mask_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [MaskW-1:0]   online_mask_out_o;
  logic [FloorW-1:0]  online_count_o;
  logic [2:0]         action_o;
  logic [WorkerW-1:0] changed_worker_o;

  // policy predictor state and its copy of the registers
  bit [MaskW-1:0] pol_mask = 16'h0001;
  int unsigned    up_run = 0;
  int unsigned    down_run = 0;
  int unsigned    cool_left = 0;
  bit             p_enable = 1'b0;
  int unsigned    p_workers = 16;
  int unsigned    p_up_need = 2;
  int unsigned    p_down_need = 8;
  int unsigned    p_cooldown = 4;

  res_t pending_results[$];
  int   mismatches = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_req = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  shard_scaling_hysteresis_policy_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .live_tasks_i       (live_tasks_i),
    .io_waiters_i       (io_waiters_i),
    .timer_armed_i      (timer_armed_i),
    .floor_count_i      (floor_count_i),
    .pressure_i         (pressure_i),
    .work_backlog_i     (work_backlog_i),
    .blocking_pending_i (blocking_pending_i),
    .opaque_blocking_i  (opaque_blocking_i),
    .drain_ok_mask_i    (drain_ok_mask_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .online_mask_out_o  (online_mask_out_o),
    .online_count_o     (online_count_o),
    .action_o           (action_o),
    .changed_worker_o   (changed_worker_o)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // one watchdog tick through the scaling policy
  function automatic res_t decide_tick(input item_t t);
    int unsigned wc, online, eff, floor_n, live, io, keep;
    bit          want_up, want_shrink;
    res_t        r;
    wc = (p_workers > 16) ? 16 : p_workers;
    live = t.live_tasks;
    io = t.io_waiters;
    floor_n = t.floor_count;
    online = $countones(pol_mask);
    r.action = ACT_NONE;
    r.changed_worker = '0;
    if (!p_enable || wc < 2) begin
      // scaling off, nothing moves
    end else if (online == 0) begin
      pol_mask = 16'h0001;
      r.action = ACT_RESTORE;
    end else begin
      eff = (live > io) ? live - io : 0;
      // waiters on a wide pool raise the floor to three quarters of it
      if (io > 0 && wc > 8) begin
        keep = wc - wc / 4;
        if (keep > floor_n) floor_n = keep;
      end
      want_up = (t.pressure || eff > online * 2 || (io > 0 && t.work_backlog) ||
                 online < floor_n) && online < wc;
      want_shrink = !t.pressure && online > floor_n && (eff + 1 < online || t.timer_armed) &&
                    !t.blocking_pending && !t.work_backlog && !t.opaque_blocking;
      if (cool_left > 0) cool_left--;
      // streaks, saturating
      if (want_up) begin
        up_run = (up_run >= 255) ? 255 : up_run + 1;
        down_run = 0;
      end else if (want_shrink) begin
        down_run = (down_run >= 255) ? 255 : down_run + 1;
        up_run = 0;
      end else begin
        up_run = 0;
        down_run = 0;
      end
      if (want_up && cool_left == 0 && up_run >= p_up_need) begin
        // lowest offline worker above worker 0
        up_run = 0;
        r.action = ACT_FAIL;
        for (int i = 1; i < int'(wc); i++) begin
          if (!pol_mask[i] && r.action == ACT_FAIL) begin
            pol_mask[i] = 1'b1;
            cool_left = p_cooldown;
            r.action = ACT_UP;
            r.changed_worker = WorkerW'(i);
          end
        end
      end else if (want_shrink && cool_left == 0 && down_run >= p_down_need) begin
        // highest drainable online worker above worker 0
        down_run = 0;
        r.action = ACT_FAIL;
        for (int i = int'(wc) - 1; i >= 1; i--) begin
          if (pol_mask[i] && t.drain_ok_mask[i] && r.action == ACT_FAIL) begin
            pol_mask[i] = 1'b0;
            cool_left = p_cooldown;
            r.action = ACT_DOWN;
            r.changed_worker = WorkerW'(i);
          end
        end
      end
    end
    r.online_mask_out = pol_mask;
    r.online_count = FloorW'($countones(pol_mask));
    return r;
  endfunction

  // random tick, shaped by kind
  function automatic item_t random_tick(input int kind);
    item_t t;
    t.live_tasks = CountW'($urandom_range(0, 65535));
    t.io_waiters = CountW'($urandom_range(0, 65535));
    t.timer_armed = 1'($urandom_range(1));
    t.floor_count = FloorW'($urandom_range(0, 16));
    t.pressure = 1'($urandom_range(1));
    t.work_backlog = 1'($urandom_range(1));
    t.blocking_pending = 1'($urandom_range(1));
    t.opaque_blocking = 1'($urandom_range(1));
    t.drain_ok_mask = MaskW'($urandom_range(0, 65535));
    if (kind == KindLoad) begin
      if ($urandom_range(1)) t.live_tasks = CountW'($urandom_range(0, 64));
      t.io_waiters = ($urandom_range(1)) ? 16'd0 : CountW'($urandom_range(1, 40));
      t.pressure = ($urandom_range(9) < 3);
      t.floor_count = ($urandom_range(1)) ? FloorW'($urandom_range(0, 4)) : t.floor_count;
      t.blocking_pending = ($urandom_range(9) < 3);
    end else if (kind == KindQuiet) begin
      t.live_tasks = CountW'($urandom_range(0, 4));
      t.io_waiters = ($urandom_range(9) < 8) ? 16'd0 : CountW'($urandom_range(1, 8));
      t.pressure = ($urandom_range(19) == 0);
      t.work_backlog = ($urandom_range(9) == 0);
      t.blocking_pending = ($urandom_range(9) == 0);
      t.opaque_blocking = ($urandom_range(9) == 0);
      t.floor_count = FloorW'($urandom_range(0, 3));
      if ($urandom_range(3) != 0) t.drain_ok_mask = 16'hFFFE;
    end
    return t;
  endfunction

  // one line per mismatch
  task automatic note_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("%0t tick result %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // send one tick and log its expected result once it is taken
  task automatic send_tick(input item_t t);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    live_tasks_i <= t.live_tasks;
    io_waiters_i <= t.io_waiters;
    timer_armed_i <= t.timer_armed;
    floor_count_i <= t.floor_count;
    pressure_i <= t.pressure;
    work_backlog_i <= t.work_backlog;
    blocking_pending_i <= t.blocking_pending;
    opaque_blocking_i <= t.opaque_blocking;
    drain_ok_mask_i <= t.drain_ok_mask;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(decide_tick(t));
  endtask

  // register write, only once every tick in flight has come back
  task automatic write_reg(input cfg_idx_e idx, input int unsigned val);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CfgDatW'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SCALING_ENABLE:  p_enable = val[0];
      CFG_WORKER_COUNT:    p_workers = val & 32'h1F;
      CFG_UP_RUN_NEEDED:   p_up_need = val & 32'hFF;
      CFG_DOWN_RUN_NEEDED: p_down_need = val & 32'hFF;
      CFG_COOLDOWN_TICKS:  p_cooldown = val & 32'hFF;
      default: ;
    endcase
  endtask

  task automatic set_policy(input int unsigned en, input int unsigned wc,
                            input int unsigned up, input int unsigned down,
                            input int unsigned cd);
    write_reg(CFG_SCALING_ENABLE, en);
    write_reg(CFG_WORKER_COUNT, wc);
    write_reg(CFG_UP_RUN_NEEDED, up);
    write_reg(CFG_DOWN_RUN_NEEDED, down);
    write_reg(CFG_COOLDOWN_TICKS, cd);
  endtask

  // tick with only the listed counts and flags set
  function automatic item_t plain_tick(input int unsigned live, input int unsigned io,
                                       input int unsigned floor_n, input bit press,
                                       input bit timers, input int unsigned drain);
    item_t t;
    t = '0;
    t.live_tasks = CountW'(live);
    t.io_waiters = CountW'(io);
    t.floor_count = FloorW'(floor_n);
    t.pressure = press;
    t.timer_armed = timers;
    t.drain_ok_mask = MaskW'(drain);
    return t;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch("with nothing outstanding, mask", online_mask_out_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (online_mask_out_o !== want.online_mask_out)
          note_mismatch("online mask", online_mask_out_o, want.online_mask_out);
        if (online_count_o !== want.online_count)
          note_mismatch("online count", online_count_o, want.online_count);
        if (action_o !== want.action)
          note_mismatch("action", action_o, want.action);
        if (changed_worker_o !== want.changed_worker)
          note_mismatch("changed worker", changed_worker_o, want.changed_worker);
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("shard_scaling_hysteresis_policy_unit: mismatch");
      $finish;
    end
  end

  // scaling off after reset: extreme ticks change nothing
  task automatic test_scaling_off();
    send_tick(plain_tick(65535, 65535, 16, 1'b1, 1'b1, 65535));
    send_tick(plain_tick(0, 0, 0, 1'b0, 1'b0, 0));
  endtask

  // zero up streak, one tick for each reason to grow
  task automatic test_scale_up();
    item_t t;
    set_policy(1, 16, 0, 1, 0);
    send_tick(plain_tick(0, 0, 0, 1'b1, 1'b0, 0));
    send_tick(plain_tick(100, 0, 0, 1'b0, 1'b0, 0));
    t = plain_tick(0, 1, 0, 1'b0, 1'b0, 0);
    t.work_backlog = 1'b1;
    send_tick(t);
    // io waiters on a wide pool raise the floor
    send_tick(plain_tick(0, 5, 0, 1'b0, 1'b0, 0));
    send_tick(plain_tick(0, 0, 16, 1'b0, 1'b0, 0));
  endtask

  // down streak of two, then no drainable worker
  task automatic test_scale_down();
    write_reg(CFG_DOWN_RUN_NEEDED, 2);
    send_tick(plain_tick(0, 0, 0, 1'b0, 1'b0, 65535));
    send_tick(plain_tick(0, 0, 0, 1'b0, 1'b0, 65535));
    send_tick(plain_tick(60, 0, 0, 1'b0, 1'b1, 0));
    send_tick(plain_tick(0, 0, 0, 1'b0, 1'b1, 0));
  endtask

  // cooldown holds back growth for its full length
  task automatic test_cooldown();
    write_reg(CFG_COOLDOWN_TICKS, 3);
    repeat (4) send_tick(plain_tick(0, 0, 0, 1'b1, 1'b0, 0));
  endtask

  // workers above a shrunken count stay and still count as online
  task automatic test_worker_limit();
    set_policy(1, 3, 1, 1, 0);
    send_tick(plain_tick(0, 0, 0, 1'b1, 1'b0, 65535));
    send_tick(plain_tick(0, 0, 0, 1'b0, 1'b1, 65535));
    write_reg(CFG_WORKER_COUNT, 0);
    send_tick(plain_tick(0, 0, 0, 1'b1, 1'b0, 65535));
  endtask

  // receiver holds off while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    set_policy(1, 16, 1, 1, 0);
    hold_req = 40;
    repeat (8) send_tick(random_tick(KindLoad));
  endtask

  // one random phase under one setting and one idling pattern
  task automatic run_policy(input int unsigned en, input int unsigned wc,
                            input int unsigned up, input int unsigned down,
                            input int unsigned cd, input int send_idle,
                            input int recv_stall, input int count);
    int sent, kind, len, pick;
    set_policy(en, wc, up, down, cd);
    idle_pct = send_idle;
    stall_pct = recv_stall;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(9);
      kind = (pick < 4) ? KindLoad : (pick < 8) ? KindQuiet : KindNoise;
      len = $urandom_range(3, 25);
      repeat (len) begin
        if (sent < count) begin
          send_tick(random_tick(kind));
          sent++;
        end
      end
    end
  endtask

  task automatic test_random_policies();
    run_policy(1, 16, 1, 1, 0, 0, 0, 115);
    run_policy(1, 4, 2, 3, 2, 60, 0, 115);
    run_policy(1, 9, 3, 8, 4, 0, 60, 115);
    run_policy(1, 2, 1, 2, 0, 26, 26, 115);
    run_policy(1, 16, 255, 255, 255, 0, 0, 115);
    run_policy(0, 16, 2, 8, 4, 60, 0, 115);
    run_policy(1, 1, 1, 1, 0, 0, 60, 115);
    run_policy(1, 12, 0, 0, 1, 26, 26, 115);
    run_policy(1, 16, 2, 8, 4, 0, 0, 115);
  endtask

  // test sequence
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_scaling_off();
    test_scale_up();
    test_scale_down();
    test_cooldown();
    test_worker_limit();
    test_backpressure();
    test_random_policies();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("shard_scaling_hysteresis_policy_unit: match");
    end else begin
      $display("shard_scaling_hysteresis_policy_unit: mismatch");
    end
    $finish;
  end

endmodule
